// ----- src/lru_pkg.sv -----
// Shared types and constants for the LRU frame replacement stack.
// Used by lru_cell and lru_frame_replacement; depends on nothing else.
package lru_pkg;

    localparam int FRAME_W = 6;
    localparam int COUNT_W = 7;

    // Per-cycle control broadcast from the sequencer to every cell
    typedef struct packed {
        logic start;    // clear the match flags for a new transaction
        logic scan;     // advance the match flags one cell up the chain
        logic commit;   // apply the reorder to the stored entries
        logic hit;      // scan outcome, valid during commit
    } lru_ctl_t;

endpackage

// ----- src/lru_cell.sv -----
// One position of the recency chain: a stored frame and its match flag.
// Depends on lru_pkg; instantiated in a row by lru_frame_replacement.
module lru_cell
    import lru_pkg::*;
#(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lru_ctl_t           ctl,
    input  logic [FRAME_W-1:0] frame,
    input  logic [CNT_W-1:0]   occupancy,
    input  logic               flag_in,
    input  logic [FRAME_W-1:0] entry_above,
    output logic [FRAME_W-1:0] entry,
    output logic               flag
);

    localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);

    logic [FRAME_W-1:0] entry_reg, entry_next;
    logic               flag_reg, flag_next;
    logic               in_use, is_last, is_append, match;

    assign in_use    = IDX < occupancy;
    assign is_last   = IDX_P1 == occupancy;
    assign is_append = IDX == occupancy;
    assign match     = in_use && (entry_reg == frame);

    always_comb
    begin
        flag_next = flag_reg;
        if (ctl.start)
        begin
            flag_next = 1'b0;
        end
        else if (ctl.scan)
        begin
            flag_next = flag_reg | match | flag_in;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.commit)
        begin
            if (ctl.hit)
            begin
                // close the gap above the hit, then place the frame on top
                if (is_last)
                begin
                    entry_next = frame;
                end
                else if (flag_reg && in_use)
                begin
                    entry_next = entry_above;
                end
            end
            else if (is_append)
            begin
                entry_next = frame;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    // Payload register: no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign flag  = flag_reg;

endmodule

// ----- src/lru_frame_replacement.sv -----
// Top level of the true-LRU replacement stack over physical page frames.
// Depends on lru_pkg and lru_cell.
// A result is registered after its transaction passes the scan, commit and report states;
// report waits for a free output register. A new reference is taken only in idle, after
// the match flag has rippled one cell per cycle along the chain and the reorder applied.
// Reset: occupancy and all control clear at once; stored frames stay undefined until written.
module lru_frame_replacement
    import lru_pkg::*;
#(
    parameter int NUM_FRAMES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FRAME_W-1:0] frame_number,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic [FRAME_W-1:0] victim_frame,
    output logic               victim_valid,
    output logic [COUNT_W-1:0] tracked_count
);

    localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
    localparam int SCAN_W = $clog2(NUM_FRAMES);
    localparam logic [CNT_W-1:0]  FULL      = CNT_W'(NUM_FRAMES);
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(NUM_FRAMES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_REPORT
    } state_t;

    state_t              state_reg, state_next;
    logic [SCAN_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_hit_reg, out_hit_next;
    logic [FRAME_W-1:0]  out_victim_reg, out_victim_next;
    logic                out_vvalid_reg, out_vvalid_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    lru_ctl_t            ctl;
    logic                in_fire, out_free, scan_hit;

    logic [FRAME_W-1:0]  entry [NUM_FRAMES];
    logic                flag  [NUM_FRAMES];

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // A match anywhere in the order has reached the top cell once the scan is done
    assign scan_hit = flag[NUM_FRAMES-1];

    assign ctl.start  = in_fire;
    assign ctl.scan   = (state_reg == ST_SCAN);
    assign ctl.commit = (state_reg == ST_COMMIT);
    assign ctl.hit    = scan_hit;

    // Row of cells: position 0 holds the least recent frame
    for (genvar i = 0; i < NUM_FRAMES; i++)
    begin : g_cell
        logic               flag_below;
        logic [FRAME_W-1:0] above;

        if (i == 0)
        begin : g_bottom
            assign flag_below = 1'b0;
        end
        else
        begin : g_inner_lo
            assign flag_below = flag[i-1];
        end

        if (i == NUM_FRAMES - 1)
        begin : g_top
            assign above = entry[i];
        end
        else
        begin : g_inner_hi
            assign above = entry[i+1];
        end

        lru_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .frame       (frame_reg),
            .occupancy   (occ_reg),
            .flag_in     (flag_below),
            .entry_above (above),
            .entry       (entry[i]),
            .flag        (flag[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        occ_next        = occ_reg;
        frame_next      = frame_reg;
        out_valid_next  = out_valid_reg;
        out_hit_next    = out_hit_reg;
        out_victim_next = out_victim_reg;
        out_vvalid_next = out_vvalid_reg;
        out_count_next  = out_count_reg;

        // drop the presented result once it is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    frame_next    = frame_number;
                    scan_cnt_next = SCAN_LAST;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // one cell of ripple per cycle, until the scan counter reaches zero
                if (scan_cnt_reg == '0)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg - 1'b1;
                end
            end
            ST_COMMIT:
            begin
                // cells reorder this cycle; a miss on a full order leaves it unchanged
                if (!scan_hit && (occ_reg != FULL))
                begin
                    occ_next = occ_reg + 1'b1;
                end
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                // hold until the output register is free, then load the result;
                // the match flags keep the scan outcome until the next transaction
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = scan_hit;
                    out_vvalid_next = (occ_reg != '0);
                    out_victim_next = (occ_reg != '0) ? entry[0] : '0;
                    out_count_next  = COUNT_W'(occ_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        frame_reg      <= frame_next;
        out_hit_reg    <= out_hit_next;
        out_victim_reg <= out_victim_next;
        out_vvalid_reg <= out_vvalid_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_hit_reg;
    assign victim_frame  = out_victim_reg;
    assign victim_valid  = out_vvalid_reg;
    assign tracked_count = out_count_reg;

    a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL)
        else $error("occupancy beyond frame capacity");

    a_miss_appends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) && !scan_hit && (occ_reg != FULL)
        |=> occ_reg == $past(occ_reg) + 1'b1)
        else $error("miss with room did not append");

    a_hit_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) && scan_hit |=> $stable(occ_reg))
        else $error("hit changed the tracked count");

    a_victim_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_vvalid_reg == (out_count_reg != '0)))
        else $error("victim valid disagrees with tracked count");

    a_hit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) && scan_hit |-> occ_reg != '0)
        else $error("hit reported on an empty order");

endmodule

// ----- tb/lru_frame_replacement_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lru_frame_replacement: frame references in, hit/victim/count out.
// Depends on lru_pkg and the lru_frame_replacement RTL; needs no files or arguments.
module lru_frame_replacement_tb;
    import lru_pkg::*;

    localparam int NUM_FRAMES     = 64;
    localparam int MAX_FRAME      = (1 << FRAME_W) - 1;
    localparam int STALL_PCT      = 38;
    // Cycles with no transaction on either side before the run is abandoned.
    // One reference occupies the block through its scan, commit and report; the rest is margin
    // for random gaps on the sender and stalls on the receiver.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = NUM_FRAMES + 8;
    localparam int MAX_REPORTS    = 10;

    // Shapes of a burst of references in the random part.
    typedef enum int {
        PICK_ANY,       // uniform over the allowed frames
        REPEAT_LAST,    // keep hitting the most recent frame
        SCAN_LOOP       // cycle through a run of frames, the classic LRU worst case
    } ref_pattern_t;

    typedef struct {
        logic               hit;
        logic [FRAME_W-1:0] victim;
        logic               victim_valid;
        logic [COUNT_W-1:0] count;
    } lru_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [FRAME_W-1:0] frame_number;
    logic               out_valid;
    logic               out_ready;
    logic               hit;
    logic [FRAME_W-1:0] victim_frame;
    logic               victim_valid;
    logic [COUNT_W-1:0] tracked_count;

    // Predicted recency order, least recent at index 0.
    logic [FRAME_W-1:0] recency_queue[$];
    lru_result_t        pending_results[$];

    bit no_idle;
    int mismatches;
    int references_sent;
    int results_checked;
    int hits_seen;
    int misses_seen;
    int peak_count;
    int quiet_cycles;

    lru_frame_replacement #(
        .NUM_FRAMES   (NUM_FRAMES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .frame_number (frame_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .victim_frame (victim_frame),
        .victim_valid (victim_valid),
        .tracked_count(tracked_count)
    );

    always #5 clk = ~clk;

    // Apply one reference to the predicted order and return the result it produces.
    // A tracked frame is pulled out and re-appended; a new one is appended while there
    // is room, and a full order is left as it stands.
    function automatic lru_result_t lru_reference(input logic [FRAME_W-1:0] frame);
        lru_result_t r;
        int          pos;
        pos = -1;
        foreach (recency_queue[i])
        begin
            if (pos < 0 && recency_queue[i] == frame)
                pos = i;
        end
        r.hit = (pos >= 0);
        if (pos >= 0)
            recency_queue.delete(pos);
        if (pos >= 0 || recency_queue.size() < NUM_FRAMES)
            recency_queue.push_back(frame);
        r.victim_valid = (recency_queue.size() > 0);
        r.victim       = r.victim_valid ? recency_queue[0] : '0;
        r.count        = COUNT_W'(recency_queue.size());
        if (r.hit)
            hits_seen++;
        else
            misses_seen++;
        if (recency_queue.size() > peak_count)
            peak_count = recency_queue.size();
        return r;
    endfunction

    // Offer one reference and hold it until the block takes it. Called at a rising edge;
    // returns at the rising edge on which the transaction was accepted.
    task automatic send_reference(input logic [FRAME_W-1:0] frame);
        if (!no_idle && $urandom_range(99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < STALL_PCT);
        end
        in_valid     <= 1'b1;
        frame_number <= frame;
        // Sample the handshake mid-cycle, where nothing is changing.
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        pending_results.push_back(lru_reference(frame));
        references_sent++;
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Hand-picked references: first one on an empty order, all-zero and all-one frame
    // numbers, a repeat of the most recent frame, a hit on the least recent frame (the
    // victim moves on) and hits in the middle of the order.
    task automatic test_directed_edges();
        logic [FRAME_W-1:0] picks[$];
        picks = '{6'd0, 6'd0, 6'd63, 6'd63, 6'd0, 6'd42, 6'd21, 6'd63,
                  6'd42, 6'd1, 6'd62, 6'd0, 6'd21};
        foreach (picks[i])
            send_reference(picks[i]);
    endtask

    // Random bursts of references over frames 0..max_frame.
    task automatic test_random_references(input int n_items, input int max_frame);
        ref_pattern_t       pattern;
        int                 sent;
        int                 burst;
        int                 scan_len;
        int                 base;
        logic [FRAME_W-1:0] frame;
        sent  = 0;
        frame = FRAME_W'($urandom_range(max_frame));
        while (sent < n_items)
        begin
            pattern  = ref_pattern_t'($urandom_range(2));
            burst    = $urandom_range(24, 2);
            scan_len = $urandom_range(max_frame + 1, 2);
            base     = $urandom_range(max_frame);
            for (int k = 0; k < burst && sent < n_items; k++)
            begin
                case (pattern)
                    PICK_ANY:    frame = FRAME_W'($urandom_range(max_frame));
                    REPEAT_LAST: frame = frame;
                    SCAN_LOOP:   frame = FRAME_W'((base + k % scan_len) % (max_frame + 1));
                    default:     frame = frame;
                endcase
                send_reference(frame);
                sent++;
            end
        end
    endtask

    // Send six references, starve the block until it has answered them all, then send six more.
    task automatic test_drain_pause();
        repeat (6)
            send_reference(FRAME_W'($urandom_range(MAX_FRAME)));
        wait_for_drain();
        repeat (6)
            send_reference(FRAME_W'($urandom_range(MAX_FRAME)));
    endtask

    // A stretch with neither side idling.
    task automatic test_back_to_back(input int n_items);
        no_idle = 1'b1;
        test_random_references(n_items, MAX_FRAME);
        no_idle = 1'b0;
    endtask

    // Receiver: stall at random, except in the back-to-back stretch.
    always @(posedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= STALL_PCT);

    // Check each result transaction against the oldest prediction. Sample mid-cycle:
    // valid and ready there are the values seen at the next rising edge.
    always @(negedge clk)
    begin : result_check
        lru_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result: hit=%0b victim=%0d valid=%0b count=%0d",
                             $realtime, hit, victim_frame, victim_valid, tracked_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit || victim_frame !== want.victim ||
                    victim_valid !== want.victim_valid || tracked_count !== want.count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"[%0t] result %0d mismatch: expected hit=%0b victim=%0d ",
                                  "valid=%0b count=%0d, got hit=%0b victim=%0d valid=%0b count=%0d"},
                                 $realtime, results_checked, want.hit, want.victim,
                                 want.victim_valid, want.count, hit, victim_frame,
                                 victim_valid, tracked_count);
                end
            end
        end
    end

    // Watchdog: abandon the run if nothing moves on either side for too long.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] timeout: no transaction for %0d cycles, %0d results outstanding",
                         $realtime, quiet_cycles, pending_results.size());
                $display("lru_frame_replacement verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        frame_number    = '0;
        out_ready       = 1'b0;
        no_idle         = 1'b0;
        mismatches      = 0;
        references_sent = 0;
        results_checked = 0;
        hits_seen       = 0;
        misses_seen     = 0;
        peak_count      = 0;
        quiet_cycles    = 0;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        // Narrow window first: plenty of hits at every depth of a part-filled order.
        test_random_references(300, 15);
        test_drain_pause();
        test_back_to_back(150);
        // Whole frame range: fills the order and then churns it.
        test_random_references(780, MAX_FRAME);

        wait_for_drain();
        // Leave room for any stray result after the last expected one.
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("covered %0d references: %0d hits, %0d misses, order reached %0d frames",
                 references_sent, hits_seen, misses_seen, peak_count);
        $display("checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("lru_frame_replacement verification clean");
        else
            $display("lru_frame_replacement verification failed");
        $finish;
    end

endmodule
